// ===== src/tws_pkg.sv =====
// tws_pkg: shared types and constants for the three-wire serial master
// depends on nothing; used by the channel interfaces and every module
package tws_pkg;

   // request codes
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // bit counts at which the command and data phases end
   localparam logic [4:0] CMD_BITS   = 5'd8;
   localparam logic [4:0] WRITE_BITS = 5'd16;
   localparam logic [4:0] READ_BITS  = 5'd8;

   localparam logic [7:0] PHASE_LENGTH_RESET = 8'd1;

   // sequencer steps
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND_LOW,
      ST_SEND_HIGH,
      ST_READ_HIGH,
      ST_READ_LOW
   } step_type;

   // one request beat
   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] addr;
      logic [7:0] write_data;
      logic       data_pin_in;
   } req_type;

   // one result beat
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       data_out;
      logic       data_drive;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       write_done;
      logic       rejected;
   } rsp_type;

endpackage

// ===== src/tws_req_if.sv =====
// tws_req_if: valid/ready channel carrying one request beat
// depends on tws_pkg
interface tws_req_if;
   import tws_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/tws_rsp_if.sv =====
// tws_rsp_if: valid/ready channel carrying one result beat
// depends on tws_pkg
interface tws_rsp_if;
   import tws_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/tws_sequencer.sv =====
// tws_sequencer: pin sequencer state, phase length register and next-state logic
// depends on tws_pkg; advances one tick per accepted request beat
module tws_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   input  logic             step_en,
   input  tws_pkg::req_type req,
   output tws_pkg::rsp_type result
);
   import tws_pkg::*;

   logic [7:0]  phase_length_ff;
   step_type    step_ff, step_in;
   logic        enable_ff, enable_in;
   logic        clock_ff, clock_in;
   logic        out_ff, out_in;
   logic        drive_ff, drive_in;
   logic [15:0] tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [4:0]  count_ff, count_in;
   logic        read_mode_ff, read_mode_in;
   logic [7:0]  divider_ff, divider_in;

   logic [7:0]  plen;
   logic        request;
   logic [7:0]  cmd;
   logic        rd_valid, wr_done, rej;
   logic [7:0]  rd_byte;

   // phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_length_ff <= PHASE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         phase_length_ff <= csr_write_data;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         enable_ff    <= 1'b0;
         clock_ff     <= 1'b0;
         out_ff       <= 1'b0;
         drive_ff     <= 1'b1;
         tx_ff        <= '0;
         rx_ff        <= '0;
         count_ff     <= '0;
         read_mode_ff <= 1'b0;
         divider_ff   <= '0;
      end else if (step_en) begin
         step_ff      <= step_in;
         enable_ff    <= enable_in;
         clock_ff     <= clock_in;
         out_ff       <= out_in;
         drive_ff     <= drive_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         count_ff     <= count_in;
         read_mode_ff <= read_mode_in;
         divider_ff   <= divider_in;
      end
   end

   // next state and result for one tick
   always_comb begin
      plen         = (phase_length_ff == 8'd0) ? 8'd1 : phase_length_ff;
      request      = (req.opcode == OP_READ) || (req.opcode == OP_WRITE);
      cmd          = {req.addr, (req.opcode == OP_READ)};
      step_in      = step_ff;
      enable_in    = enable_ff;
      clock_in     = clock_ff;
      out_in       = out_ff;
      drive_in     = drive_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      count_in     = count_ff;
      read_mode_in = read_mode_ff;
      divider_in   = divider_ff;
      rd_valid     = 1'b0;
      wr_done      = 1'b0;
      rej          = 1'b0;
      rd_byte      = 8'd0;

      if (step_ff == ST_IDLE) begin
         // start a transaction with enable high and clock low
         if (request) begin
            read_mode_in = (req.opcode == OP_READ);
            tx_in        = {req.write_data, cmd};
            enable_in    = 1'b1;
            clock_in     = 1'b0;
            drive_in     = 1'b1;
            out_in       = cmd[0];
            count_in     = 5'd0;
            divider_in   = 8'd1;
            step_in      = ST_SEND_LOW;
         end
      end else begin
         rej = request;
         if (divider_ff < plen) begin
            divider_in = divider_ff + 8'd1;
         end else begin
            divider_in = 8'd1;
            case (step_ff)
               ST_SEND_LOW: begin
                  clock_in = 1'b1;
                  step_in  = ST_SEND_HIGH;
               end
               ST_SEND_HIGH: begin
                  tx_in    = {1'b0, tx_ff[15:1]};
                  count_in = count_ff + 5'd1;
                  if (read_mode_ff && count_in >= CMD_BITS) begin
                     // command done: release the line for the read
                     drive_in = 1'b0;
                     out_in   = 1'b0;
                     count_in = 5'd0;
                     step_in  = ST_READ_HIGH;
                  end else if (!read_mode_ff && count_in >= WRITE_BITS) begin
                     step_in    = ST_IDLE;
                     enable_in  = 1'b0;
                     clock_in   = 1'b0;
                     out_in     = 1'b0;
                     drive_in   = 1'b1;
                     count_in   = 5'd0;
                     divider_in = 8'd0;
                     wr_done    = 1'b1;
                  end else begin
                     clock_in = 1'b0;
                     out_in   = tx_in[0];
                     step_in  = ST_SEND_LOW;
                  end
               end
               ST_READ_HIGH: begin
                  clock_in = 1'b0;
                  step_in  = ST_READ_LOW;
               end
               ST_READ_LOW: begin
                  // sample the pin after the falling edge, lsb first
                  rx_in    = {req.data_pin_in, rx_ff[7:1]};
                  count_in = count_ff + 5'd1;
                  if (count_in >= READ_BITS) begin
                     step_in    = ST_IDLE;
                     enable_in  = 1'b0;
                     clock_in   = 1'b0;
                     out_in     = 1'b0;
                     drive_in   = 1'b1;
                     count_in   = 5'd0;
                     divider_in = 8'd0;
                     rd_valid   = 1'b1;
                     rd_byte    = rx_in;
                  end else begin
                     clock_in = 1'b1;
                     step_in  = ST_READ_HIGH;
                  end
               end
               default: begin
                  step_in    = ST_IDLE;
                  enable_in  = 1'b0;
                  clock_in   = 1'b0;
                  out_in     = 1'b0;
                  drive_in   = 1'b1;
                  count_in   = 5'd0;
                  divider_in = 8'd0;
               end
            endcase
         end
      end

      result.chip_enable  = enable_in;
      result.serial_clock = clock_in;
      result.data_out     = drive_in & out_in;
      result.data_drive   = drive_in;
      result.busy_res     = (step_in != ST_IDLE);
      result.read_data    = rd_byte;
      result.read_valid   = rd_valid;
      result.write_done   = wr_done;
      result.rejected     = rej;
   end

endmodule

// ===== src/tws_out_stage.sv =====
// tws_out_stage: result register between the sequencer and the result channel
// depends on tws_pkg
module tws_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tws_pkg::rsp_type result,
   output logic             space,
   tws_rsp_if.source        rsp_chan
);
   import tws_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // register can take a beat when empty or being drained
   assign space = !valid_ff || rsp_chan.ready;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= load;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;

endmodule

// ===== src/three_wire_serial_rtc_master_top.sv =====
// three_wire_serial_rtc_master_top: three-wire serial clock-chip master, lsb first
// depends on tws_pkg, tws_req_if, tws_rsp_if, tws_sequencer, tws_out_stage
//
//   channel   direction  contents
//   req_chan  in         one tick: opcode, addr, write_data, data_pin_in
//   rsp_chan  out        pin levels and status after that tick
//   csr_*     in         phase_length write, no read-back
//
// each request beat is one tick; the sequencer updates in the cycle it
// accepts the beat and the result is registered, appearing in the cycle after,
// and one beat per cycle is taken while the result register drains.
// reset is synchronous: idle, pins low, data driven, phase length 1.
// a stalled result register holds req_chan.ready low and freezes the sequencer.
module three_wire_serial_rtc_master_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   tws_req_if.sink    req_chan,
   tws_rsp_if.source  rsp_chan
);
   import tws_pkg::*;

   logic    space;
   logic    accept;
   rsp_type result;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   // tick sequencer
   tws_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step_en          (accept),
      .req              (req_chan.payload),
      .result           (result)
   );

   // result register
   tws_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule
